FILE: rtl/grid_astar_path_search_assert.svh
// Assertion macros used by the grid path search datapath.
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
`define GAPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define GAPS_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define GAPS_ASSERT(lbl, clk, rst, prop)
`define GAPS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/gaps_pkg.sv
package gaps_pkg;

   localparam int ROWS     = 8;
   localparam int COLS     = 8;
   localparam int CELLS    = 64;
   localparam int CELL_W   = 6;
   localparam int OPEN_MAX = 64;
   localparam int CNT_W    = 7;
   localparam int G_W      = 6;
   localparam int F_W      = 7;
   localparam int ENT_W    = F_W + G_W + CELL_W;

   localparam logic [G_W-1:0] G_MAX = 6'd63;
   localparam logic [F_W-1:0] F_MAX = 7'd127;
   localparam logic [5:0]     TRACE_MAX = 6'd63;

   // Result status codes.
   localparam logic [2:0] ST_PATH    = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_BLOCKED = 3'd2;
   localparam logic [2:0] ST_THERE   = 3'd3;
   localparam logic [2:0] ST_NOPATH  = 3'd4;

   // Neighbor offsets: N, W, S, E, NW, NE, SW, SE.
   localparam logic signed [4:0] STEP_DR [8] = '{-5'sd1, 5'sd0, 5'sd1, 5'sd0,
                                                -5'sd1, -5'sd1, 5'sd1, 5'sd1};
   localparam logic signed [4:0] STEP_DC [8] = '{5'sd0, -5'sd1, 5'sd0, 5'sd1,
                                                -5'sd1, 5'sd1, -5'sd1, 5'sd1};

   typedef enum logic [1:0] {
      NB_SKIP = 2'd0,
      NB_DST  = 2'd1,
      NB_EVAL = 2'd2
   } nb_kind_type;

   typedef struct packed {
      logic       grid_wr;
      logic       start;
      logic       init;
      logic       scan_clr;
      logic       scan_rd;
      logic       scan_cmp;
      logic       pop_rd;
      logic       pop_wr;
      logic       nb_eval;
      logic       nb_upd;
      logic       nb_next;
      logic       tr_rd;
      logic       tr_load;
      logic       tr_next;
      logic       out_status;
      logic [2:0] status_code;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  chk_code;
      logic        cnt_zero;
      logic        scan_last;
      logic        nb_last;
      nb_kind_type nb_kind;
      logic        rsp_last;
   } sts_type;

endpackage

FILE: rtl/gaps_ctrl.sv
module gaps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  gaps_pkg::sts_type sts,
   output gaps_pkg::cmd_type cmd
);
   import gaps_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_CHECK    = 12'b000000000010,
      S_SCAN_CHK = 12'b000000000100,
      S_SCAN_RD  = 12'b000000001000,
      S_SCAN_CMP = 12'b000000010000,
      S_POP_RD   = 12'b000000100000,
      S_POP_WR   = 12'b000001000000,
      S_NB_EVAL  = 12'b000010000000,
      S_NB_UPD   = 12'b000100000000,
      S_TR_RD    = 12'b001000000000,
      S_TR_OUT   = 12'b010000000000,
      S_OUT_WAIT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT_WAIT);

   // Next state and commands to the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op) begin
                  cmd.start = 1'b1;
                  state_in  = S_CHECK;
               end else begin
                  cmd.grid_wr = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (sts.chk_code != ST_PATH) begin
               cmd.out_status  = 1'b1;
               cmd.status_code = sts.chk_code;
               state_in        = S_OUT_WAIT;
            end else begin
               cmd.init = 1'b1;
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (sts.cnt_zero) begin
               cmd.out_status  = 1'b1;
               cmd.status_code = ST_NOPATH;
               state_in        = S_OUT_WAIT;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = sts.scan_last ? S_POP_RD : S_SCAN_RD;
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP_WR;
         end
         S_POP_WR: begin
            cmd.pop_wr = 1'b1;
            state_in   = S_NB_EVAL;
         end
         S_NB_EVAL: begin
            cmd.nb_eval = 1'b1;
            unique case (sts.nb_kind)
               NB_DST:  state_in = S_TR_RD;
               NB_EVAL: state_in = S_NB_UPD;
               default: begin
                  cmd.nb_next = 1'b1;
                  state_in    = sts.nb_last ? S_SCAN_CHK : S_NB_EVAL;
               end
            endcase
         end
         S_NB_UPD: begin
            cmd.nb_upd  = 1'b1;
            cmd.nb_next = 1'b1;
            state_in    = sts.nb_last ? S_SCAN_CHK : S_NB_EVAL;
         end
         S_TR_RD: begin
            cmd.tr_rd = 1'b1;
            state_in  = S_TR_OUT;
         end
         S_TR_OUT: begin
            cmd.tr_load = 1'b1;
            state_in    = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               if (sts.rsp_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.tr_next = 1'b1;
                  state_in    = S_TR_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gaps_dp.sv
`include "grid_astar_path_search_assert.svh"
module gaps_dp (
   input  logic              clock,
   input  logic              reset,
   input  gaps_pkg::cmd_type cmd,
   output gaps_pkg::sts_type sts,
   input  logic [2:0]        req_cell_row,
   input  logic [2:0]        req_cell_col,
   input  logic              req_cell_open,
   input  logic [3:0]        req_src_row,
   input  logic [3:0]        req_src_col,
   input  logic [3:0]        req_dst_row,
   input  logic [3:0]        req_dst_col,
   output logic [2:0]        rsp_status,
   output logic [2:0]        rsp_path_row,
   output logic [2:0]        rsp_path_col,
   output logic              rsp_last
);
   import gaps_pkg::*;

   // Grid, closed marks and score valid bits live in flip-flops.
   logic [CELLS-1:0] grid_ff, closed_ff, svld_ff;
   logic [F_W-1:0]    score_mem  [CELLS];
   logic [CELL_W-1:0] parent_mem [CELLS];
   logic [ENT_W-1:0]  open_mem   [OPEN_MAX];

   logic [3:0]        sr_ff, sc_ff, dr_ff, dc_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CELL_W-1:0] idx_ff, best_idx_ff, cur_ff, at_ff, n_ff;
   logic [ENT_W-1:0]  best_ent_ff, open_rd_ff;
   logic [G_W-1:0]    g_ff;
   logic [2:0]        k_ff;
   logic [F_W-1:0]    score_rd_ff;
   logic [CELL_W-1:0] parent_rd_ff;
   logic [2:0]        status_ff, row_ff, col_ff;
   logic              last_ff;

   logic [CELL_W-1:0] src_cell, dst_cell, nb_cell;
   logic [3:0]        cur_r, cur_c, a_dist, b_dist, h_dist;
   logic signed [4:0] nr_s, nc_s;
   logic              nb_oob, improve, tr_end;
   logic [G_W-1:0]    gn;
   logic [F_W-1:0]    fn, score_cur;

   assign rsp_status   = status_ff;
   assign rsp_path_row = row_ff;
   assign rsp_path_col = col_ff;
   assign rsp_last     = last_ff;

   // Endpoint checks and neighbor arithmetic.
   always_comb begin
      src_cell = CELL_W'(32'(sr_ff) * COLS + 32'(sc_ff));
      dst_cell = CELL_W'(32'(dr_ff) * COLS + 32'(dc_ff));
      if (32'(sr_ff) >= ROWS || 32'(sc_ff) >= COLS ||
          32'(dr_ff) >= ROWS || 32'(dc_ff) >= COLS) begin
         sts.chk_code = ST_INVALID;
      end else if (!grid_ff[src_cell] || !grid_ff[dst_cell]) begin
         sts.chk_code = ST_BLOCKED;
      end else if (src_cell == dst_cell) begin
         sts.chk_code = ST_THERE;
      end else begin
         sts.chk_code = ST_PATH;
      end

      cur_r   = 4'(cur_ff / COLS);
      cur_c   = 4'(cur_ff % COLS);
      nr_s    = $signed({1'b0, cur_r}) + STEP_DR[k_ff];
      nc_s    = $signed({1'b0, cur_c}) + STEP_DC[k_ff];
      nb_oob  = (nr_s < 0) || (32'(nr_s) >= ROWS) || (nc_s < 0) || (32'(nc_s) >= COLS);
      nb_cell = CELL_W'(32'(nr_s[3:0]) * COLS + 32'(nc_s[3:0]));
      a_dist  = (nr_s[3:0] > dr_ff) ? nr_s[3:0] - dr_ff : dr_ff - nr_s[3:0];
      b_dist  = (nc_s[3:0] > dc_ff) ? nc_s[3:0] - dc_ff : dc_ff - nc_s[3:0];
      h_dist  = (a_dist > b_dist) ? a_dist : b_dist;
      gn      = (g_ff == G_MAX) ? G_MAX : g_ff + 1'b1;
      fn      = F_W'(gn) + F_W'(h_dist);

      if (nb_oob) begin
         sts.nb_kind = NB_SKIP;
      end else if (nb_cell == dst_cell) begin
         sts.nb_kind = NB_DST;
      end else if (closed_ff[nb_cell] || !grid_ff[nb_cell]) begin
         sts.nb_kind = NB_SKIP;
      end else begin
         sts.nb_kind = NB_EVAL;
      end

      score_cur     = svld_ff[nb_cell] ? score_rd_ff : F_MAX;
      improve       = score_cur > fn;
      tr_end        = (parent_rd_ff == at_ff) || (n_ff == TRACE_MAX);
      sts.cnt_zero  = (cnt_ff == '0);
      sts.scan_last = (CNT_W'(idx_ff) + 1'b1) == cnt_ff;
      sts.nb_last   = (k_ff == 3'd7);
      sts.rsp_last  = last_ff;
   end

   // Control-like state: grid, marks, open count.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff   <= '0;
         closed_ff <= '0;
         svld_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.grid_wr && 32'(req_cell_row) < ROWS && 32'(req_cell_col) < COLS) begin
            grid_ff[CELL_W'(32'(req_cell_row) * COLS + 32'(req_cell_col))] <= req_cell_open;
         end
         if (cmd.init) begin
            closed_ff         <= '0;
            svld_ff           <= '0;
            svld_ff[src_cell] <= 1'b1;
            cnt_ff            <= CNT_W'(1);
         end
         if (cmd.pop_wr) begin
            closed_ff[best_ent_ff[CELL_W-1:0]] <= 1'b1;
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.nb_upd && improve) begin
            svld_ff[nb_cell] <= 1'b1;
            if (cnt_ff < CNT_W'(OPEN_MAX)) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   // Open list memory.
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         open_mem[0] <= {F_W'(0), G_W'(0), src_cell};
      end else if (cmd.pop_wr) begin
         open_mem[best_idx_ff] <= open_rd_ff;
      end else if (cmd.nb_upd && improve && cnt_ff < CNT_W'(OPEN_MAX)) begin
         open_mem[cnt_ff[CELL_W-1:0]] <= {fn, gn, nb_cell};
      end
      if (cmd.scan_rd) begin
         open_rd_ff <= open_mem[idx_ff];
      end else if (cmd.pop_rd) begin
         open_rd_ff <= open_mem[CELL_W'(cnt_ff - 1'b1)];
      end
   end

   // Score memory.
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         score_mem[src_cell] <= '0;
      end else if (cmd.nb_upd && improve) begin
         score_mem[nb_cell] <= fn;
      end
      if (cmd.nb_eval) begin
         score_rd_ff <= score_mem[nb_cell];
      end
   end

   // Parent memory.
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         parent_mem[src_cell] <= src_cell;
      end else if (cmd.nb_eval && sts.nb_kind == NB_DST) begin
         parent_mem[dst_cell] <= cur_ff;
      end else if (cmd.nb_upd && improve) begin
         parent_mem[nb_cell] <= cur_ff;
      end
      if (cmd.tr_rd) begin
         parent_rd_ff <= parent_mem[at_ff];
      end
   end

   // Search registers and the result register.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sr_ff <= req_src_row;
         sc_ff <= req_src_col;
         dr_ff <= req_dst_row;
         dc_ff <= req_dst_col;
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end
      if (cmd.scan_cmp) begin
         if (idx_ff == '0 || open_rd_ff[ENT_W-1 -: F_W] < best_ent_ff[ENT_W-1 -: F_W]) begin
            best_idx_ff <= idx_ff;
            best_ent_ff <= open_rd_ff;
         end
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.pop_wr) begin
         cur_ff <= best_ent_ff[CELL_W-1:0];
         g_ff   <= best_ent_ff[CELL_W +: G_W];
         k_ff   <= '0;
      end
      if (cmd.nb_next) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.nb_eval && sts.nb_kind == NB_DST) begin
         at_ff <= dst_cell;
         n_ff  <= '0;
      end
      if (cmd.tr_next) begin
         at_ff <= parent_rd_ff;
         n_ff  <= n_ff + 1'b1;
      end
      if (cmd.out_status) begin
         status_ff <= cmd.status_code;
         row_ff    <= '0;
         col_ff    <= '0;
         last_ff   <= 1'b1;
      end
      if (cmd.tr_load) begin
         status_ff <= ST_PATH;
         row_ff    <= 3'(at_ff / COLS);
         col_ff    <= 3'(at_ff % COLS);
         last_ff   <= tr_end;
      end
   end

   `GAPS_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(OPEN_MAX))
   `GAPS_ASSERT(a_pop_nonempty, clock, reset, cmd.pop_wr |-> cnt_ff != '0)
   `GAPS_ASSERT(a_pop_closes, clock, reset, cmd.pop_wr |=> closed_ff[cur_ff])

endmodule

FILE: rtl/grid_astar_path_search.sv
// A grid write is accepted from the idle state, and the next request may follow at once.
// A search request first checks its endpoints; an early status result then waits in the
// output register. Each expansion scans the open list, pops the best entry and checks the
// eight neighbors; each path cell is read from the parent memory and held until rsp_ready.
// One request is processed at a time; results leave through a single output register.
// Synchronous active-high reset blocks the whole grid and empties the open list.
module grid_astar_path_search (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [2:0] req_cell_row,
   input  logic [2:0] req_cell_col,
   input  logic       req_cell_open,
   input  logic [3:0] req_src_row,
   input  logic [3:0] req_src_col,
   input  logic [3:0] req_dst_row,
   input  logic [3:0] req_dst_col,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_path_row,
   output logic [2:0] rsp_path_col,
   output logic       rsp_last
);
   import gaps_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   gaps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   gaps_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_cell_row  (req_cell_row),
      .req_cell_col  (req_cell_col),
      .req_cell_open (req_cell_open),
      .req_src_row   (req_src_row),
      .req_src_col   (req_src_col),
      .req_dst_row   (req_dst_row),
      .req_dst_col   (req_dst_col),
      .rsp_status    (rsp_status),
      .rsp_path_row  (rsp_path_row),
      .rsp_path_col  (rsp_path_col),
      .rsp_last      (rsp_last)
   );

endmodule
